### sv/hjd_pkg.sv
`default_nettype none

package hjd_pkg;

   // Number of count bytes at the head of a table, one per code length.
   localparam int COUNT_BYTES = 16;
   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] ST_SYMBOL  = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_LOADED  = 2'd2;

   // One queued unit of back-end work: an optional symbol store write and an
   // optional result. A symbol result reads the store at addr.
   typedef struct packed {
      logic       wr;
      logic       res;
      logic [7:0] addr;
      logic [7:0] data;
      logic [1:0] status;
      logic [4:0] code_length;
      logic [8:0] bytes_read;
      logic       overfull;
   } hjd_entry_type;

endpackage

`default_nettype wire

### sv/hjd_ram.sv
`default_nettype none

module hjd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/hjd_front.sv
`default_nettype none

module hjd_front #(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int SYMBOL_DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic                  req_table_start,
   input  wire logic [7:0]            req_data,
   output logic                       push_valid,
   output hjd_pkg::hjd_entry_type     push_entry,
   input  wire logic                  push_ready
);

   import hjd_pkg::*;

   // Per-length table, built one length per count byte.
   logic [16:0] code_limit_ff  [COUNT_BYTES];
   logic [16:0] first_code_ff  [COUNT_BYTES];
   logic [8:0]  first_index_ff [COUNT_BYTES];

   logic [8:0]  load_pos_ff, load_pos_in;
   logic        table_valid_ff, table_valid_in;
   logic        ovf_seen_ff, ovf_seen_in;
   logic        ovf_acc_ff, ovf_acc_in;
   logic [16:0] next_code_ff, next_code_in;
   logic [8:0]  prefix_ff, prefix_in;
   logic [4:0]  longest_ff, longest_in;
   logic [15:0] accum_ff, accum_in;
   logic [4:0]  bits_ff, bits_in;
   logic        tbl_wr;

   logic        accept;
   logic [8:0]  pos;
   logic        valid_now;

   // Count byte path.
   logic        first_len;
   logic [3:0]  len_idx;
   logic [4:0]  len5;
   logic [8:0]  base_prefix;
   logic [16:0] base_nc;
   logic [4:0]  base_longest;
   logic        base_ovf;
   logic [8:0]  avail;
   logic        trunc;
   logic [7:0]  n_take;
   logic        in_range;
   logic [16:0] space;
   logic        over_space;
   logic [7:0]  placed;
   logic [16:0] limit_new;
   logic [16:0] nc_new;
   logic [4:0]  longest_new;
   logic        ovf_new;
   logic [8:0]  prefix_new;

   // Coded bit path.
   logic [3:0]  bit_idx;
   logic [15:0] acc_new;
   logic [4:0]  len_d;
   logic [16:0] lim;
   logic [16:0] fc;
   logic        hit;
   logic [16:0] offset;
   logic [8:0]  sym_index;
   logic        give_up;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign pos       = req_table_start ? '0 : load_pos_ff;
   assign valid_now = req_table_start ? 1'b0 : table_valid_ff;

   assign len_idx      = pos[3:0];
   assign first_len    = (len_idx == '0);
   assign len5         = {1'b0, len_idx} + 5'd1;
   assign base_prefix  = first_len ? '0 : prefix_ff;
   assign base_nc      = first_len ? '0 : next_code_ff;
   assign base_longest = first_len ? 5'd1 : longest_ff;
   assign base_ovf     = first_len ? 1'b0 : ovf_acc_ff;

   // Counts beyond the symbol store are cut short.
   assign avail  = 9'(SYMBOL_DEPTH) - base_prefix;
   assign trunc  = {1'b0, req_data} > avail;
   assign n_take = trunc ? avail[7:0] : req_data;

   assign in_range   = len5 <= 5'(MAX_CODE_LENGTH);
   assign space      = (17'd1 << len5) - base_nc;
   assign over_space = {9'b0, n_take} > space;
   assign placed     = over_space ? space[7:0] : n_take;
   assign limit_new  = in_range ? base_nc + {9'b0, placed} : '0;
   assign nc_new     = !in_range ? base_nc
                     : (len5 < 5'(MAX_CODE_LENGTH)) ? {limit_new[15:0], 1'b0} : limit_new;
   assign longest_new = (in_range && placed != '0) ? len5 : base_longest;
   assign ovf_new    = base_ovf | trunc | (in_range ? over_space : (n_take != '0));
   assign prefix_new = base_prefix + {1'b0, n_take};

   assign bit_idx   = bits_ff[3:0];
   assign acc_new   = {accum_ff[14:0], req_data[0]};
   assign len_d     = bits_ff + 5'd1;
   assign lim       = code_limit_ff[bit_idx];
   assign fc        = first_code_ff[bit_idx];
   assign hit       = ({1'b0, acc_new} < lim) && ({1'b0, acc_new} >= fc);
   assign offset    = {1'b0, acc_new} - fc;
   assign sym_index = first_index_ff[bit_idx] + offset[8:0];
   assign give_up   = len_d >= longest_ff;

   always_comb begin
      load_pos_in    = load_pos_ff;
      table_valid_in = table_valid_ff;
      ovf_seen_in    = ovf_seen_ff;
      ovf_acc_in     = ovf_acc_ff;
      next_code_in   = next_code_ff;
      prefix_in      = prefix_ff;
      longest_in     = longest_ff;
      accum_in       = accum_ff;
      bits_in        = bits_ff;
      tbl_wr         = 1'b0;
      push_valid     = 1'b0;
      push_entry     = '0;
      if (accept) begin
         if (!req_kind) begin
            if (req_table_start) begin
               accum_in       = '0;
               bits_in        = '0;
               table_valid_in = 1'b0;
               ovf_seen_in    = 1'b0;
               load_pos_in    = '0;
            end
            if (!valid_now) begin
               load_pos_in = pos + 9'd1;
               if (pos < 9'(COUNT_BYTES)) begin
                  tbl_wr       = 1'b1;
                  prefix_in    = prefix_new;
                  next_code_in = nc_new;
                  longest_in   = longest_new;
                  ovf_acc_in   = ovf_new;
                  // An empty table finishes on the last count byte.
                  if (pos == 9'(COUNT_BYTES - 1) && prefix_new == '0) begin
                     table_valid_in        = 1'b1;
                     ovf_seen_in           = ovf_new;
                     push_valid            = 1'b1;
                     push_entry.res        = 1'b1;
                     push_entry.status     = ST_LOADED;
                     push_entry.bytes_read = pos + 9'd1;
                     push_entry.overfull   = ovf_new;
                  end
               end else begin
                  push_valid      = 1'b1;
                  push_entry.wr   = 1'b1;
                  push_entry.addr = 8'(pos - 9'(COUNT_BYTES));
                  push_entry.data = req_data;
                  if (pos - 9'(COUNT_BYTES - 1) >= prefix_ff) begin
                     table_valid_in        = 1'b1;
                     ovf_seen_in           = ovf_acc_ff;
                     push_entry.res        = 1'b1;
                     push_entry.status     = ST_LOADED;
                     push_entry.bytes_read = pos + 9'd1;
                     push_entry.overfull   = ovf_acc_ff;
                  end
               end
            end
         end else if (!table_valid_ff) begin
            accum_in               = '0;
            bits_in                = '0;
            push_valid             = 1'b1;
            push_entry.res         = 1'b1;
            push_entry.status      = ST_INVALID;
            push_entry.code_length = 5'd1;
            push_entry.overfull    = ovf_seen_ff;
         end else if (hit) begin
            accum_in               = '0;
            bits_in                = '0;
            push_valid             = 1'b1;
            push_entry.res         = 1'b1;
            push_entry.status      = ST_SYMBOL;
            push_entry.addr        = sym_index[7:0];
            push_entry.code_length = len_d;
            push_entry.overfull    = ovf_seen_ff;
         end else if (give_up) begin
            accum_in               = '0;
            bits_in                = '0;
            push_valid             = 1'b1;
            push_entry.res         = 1'b1;
            push_entry.status      = ST_INVALID;
            push_entry.code_length = len_d;
            push_entry.overfull    = ovf_seen_ff;
         end else begin
            accum_in = acc_new;
            bits_in  = len_d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff    <= '0;
         table_valid_ff <= 1'b0;
         ovf_seen_ff    <= 1'b0;
         accum_ff       <= '0;
         bits_ff        <= '0;
      end else begin
         load_pos_ff    <= load_pos_in;
         table_valid_ff <= table_valid_in;
         ovf_seen_ff    <= ovf_seen_in;
         accum_ff       <= accum_in;
         bits_ff        <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_acc_ff   <= ovf_acc_in;
      next_code_ff <= next_code_in;
      prefix_ff    <= prefix_in;
      longest_ff   <= longest_in;
      if (tbl_wr) begin
         code_limit_ff[len_idx]  <= limit_new;
         first_code_ff[len_idx]  <= base_nc;
         first_index_ff[len_idx] <= base_prefix;
      end
   end

`ifndef SYNTHESIS
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff < 5'(MAX_CODE_LENGTH))
      else $error("partial code grew past the longest code length");

   a_no_partial_while_loading: assert property (@(posedge clock) disable iff (reset)
      !table_valid_ff |-> (bits_ff == '0 && accum_ff == '0))
      else $error("partial code held while no table is valid");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("queue push without room");
`endif

endmodule

`default_nettype wire

### sv/hjd_queue.sv
`default_nettype none

module hjd_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire hjd_pkg::hjd_entry_type push_entry,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output hjd_pkg::hjd_entry_type      pop_entry
);

   import hjd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   hjd_entry_type  slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy beyond its depth");
`endif

endmodule

`default_nettype wire

### sv/hjd_back.sv
`default_nettype none

module hjd_back #(
   parameter int SYMBOL_DEPTH = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire hjd_pkg::hjd_entry_type pop_entry,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [7:0]                  rsp_symbol,
   output logic [4:0]                  rsp_code_length,
   output logic [8:0]                  rsp_bytes_read,
   output logic                        rsp_overfull
);

   import hjd_pkg::*;

   localparam int AW = $clog2(SYMBOL_DEPTH);

   logic          fire;
   logic          wr_en;
   logic          rd_en;
   logic [7:0]    rd_data;
   logic          out_free;

   // Lookup stage: the store read data lines up with this register.
   logic          look_valid_ff, look_valid_in;
   hjd_entry_type look_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [7:0]    rsp_symbol_ff;
   logic [4:0]    rsp_code_length_ff;
   logic [8:0]    rsp_bytes_read_ff;
   logic          rsp_overfull_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !look_valid_ff || out_free;
   assign fire      = pop_valid && pop_ready;
   assign wr_en     = fire && pop_entry.wr;
   assign rd_en     = fire && pop_entry.res && (pop_entry.status == ST_SYMBOL);
   assign look_valid_in = pop_ready ? (fire && pop_entry.res) : look_valid_ff;

   hjd_ram #(
      .WIDTH (8),
      .DEPTH (SYMBOL_DEPTH)
   ) u_symbol_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pop_entry.addr[AW-1:0]),
      .wr_data (pop_entry.data),
      .rd_en   (rd_en),
      .rd_addr (pop_entry.addr[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         look_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         look_valid_ff <= look_valid_in;
         if (out_free) begin
            rsp_valid_ff <= look_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready) begin
         look_ff <= pop_entry;
      end
      if (out_free) begin
         rsp_status_ff      <= look_ff.status;
         rsp_symbol_ff      <= (look_ff.status == ST_SYMBOL) ? rd_data : '0;
         rsp_code_length_ff <= look_ff.code_length;
         rsp_bytes_read_ff  <= look_ff.bytes_read;
         rsp_overfull_ff    <= look_ff.overfull;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_symbol      = rsp_symbol_ff;
   assign rsp_code_length = rsp_code_length_ff;
   assign rsp_bytes_read  = rsp_bytes_read_ff;
   assign rsp_overfull    = rsp_overfull_ff;

`ifndef SYNTHESIS
   a_one_store_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("symbol store written and looked up in the same cycle");

   a_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      (look_valid_ff && !out_free) |=> (look_valid_ff && $stable(rd_data)))
      else $error("lookup stage lost its data while the output stalled");
`endif

endmodule

`default_nettype wire

### sv/jpeg_huffman_table_decoder_top.sv
`default_nettype none

// JPEG canonical Huffman table decoder.
// Request channel (req_*): one transaction per table byte (req_kind 0) or per
// coded bit (req_kind 1, bit in req_data[0]). req_table_start on the first
// count byte begins a new table. Sixteen count bytes, then the symbols, are
// loaded; the last byte of a table gives a status 2 result with bytes_read.
// Coded bits, most significant first, give status 0 with the symbol and code
// length once a code completes, or status 1 when a code cannot match.
// Response channel (rsp_*): one transaction per result; most requests give none.
// Throughput is one request per cycle while the queue has room; the table
// is built one length per count byte, so a bit may follow the last table
// byte directly. From request to response, the front writes the transaction
// into a two-entry queue, the back pops it into the lookup stage and reads
// the symbol store (registered read), and the output register presents it.
// A stalled response fills the lookup stage and then the queue; req_ready
// falls only when the queue is full.
// Reset (synchronous, active high) empties the pipeline and leaves no table
// valid; the next table bytes load a table even without req_table_start.
module jpeg_huffman_table_decoder_top #(
   parameter int MAX_CODE_LENGTH = 16,
   parameter int SYMBOL_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic       req_table_start,
   input  wire logic [7:0] req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_symbol,
   output logic [4:0]      rsp_code_length,
   output logic [8:0]      rsp_bytes_read,
   output logic            rsp_overfull
);

   import hjd_pkg::*;

   logic          push_valid;
   logic          push_ready;
   hjd_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   hjd_entry_type pop_entry;

   hjd_front #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .SYMBOL_DEPTH    (SYMBOL_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_table_start (req_table_start),
      .req_data        (req_data),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .push_ready      (push_ready)
   );

   hjd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   hjd_back #(
      .SYMBOL_DEPTH (SYMBOL_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_symbol      (rsp_symbol),
      .rsp_code_length (rsp_code_length),
      .rsp_bytes_read  (rsp_bytes_read),
      .rsp_overfull    (rsp_overfull)
   );

endmodule

`default_nettype wire

### bench/tb_jpeg_huffman_table_decoder_top.sv
`timescale 1ns / 1ps

module tb_jpeg_huffman_table_decoder_top;
   import hjd_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] symbol;
      logic [4:0] code_length;
      logic [8:0] bytes_read;
      logic       overfull;
   } dec_result_type;

   typedef struct packed {
      logic           kind;
      logic           start;
      logic [7:0]     data;
      logic           typed;
      dec_result_type res;
   } script_row_type;

   localparam int MAX_LEN = 16;
   localparam int STORE_DEPTH = 256;
   localparam int SCRIPT_LEN = 26;
   localparam int ITEM_TARGET = 800;
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_BIT = 1'b1;
   localparam int PROF_CANON = 0;
   localparam int PROF_EMPTY = 1;
   localparam int PROF_OVER = 2;
   localparam int PROF_HUGE = 3;
   localparam dec_result_type NO_RES = '0;

   // Table with lengths 1, 2 and 3 holding 1, 2 and 1 codes: the length-3 symbol
   // finds the code space already full. The first count byte comes without
   // table_start, after reset and a coded bit that finds no table valid.
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{KIND_BIT,  1'b1, 8'hFF, 1'b1, '{ST_INVALID, 8'h00, 5'd1, 9'd0, 1'b0}},
      '{KIND_BYTE, 1'b0, 8'd1,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd2,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd1,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'd0,  1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'h00, 1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'hFF, 1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'h5A, 1'b0, NO_RES},
      '{KIND_BYTE, 1'b0, 8'hA5, 1'b1, '{ST_LOADED, 8'h00, 5'd0, 9'd20, 1'b1}},
      '{KIND_BYTE, 1'b0, 8'h33, 1'b0, NO_RES},
      '{KIND_BIT,  1'b0, 8'hFE, 1'b1, '{ST_SYMBOL, 8'h00, 5'd1, 9'd0, 1'b1}},
      '{KIND_BIT,  1'b0, 8'h01, 1'b0, NO_RES},
      '{KIND_BIT,  1'b1, 8'h80, 1'b1, '{ST_SYMBOL, 8'hFF, 5'd2, 9'd0, 1'b1}},
      '{KIND_BIT,  1'b0, 8'h7F, 1'b0, NO_RES}
   };

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_kind = 1'b0;
   logic       req_table_start = 1'b0;
   logic [7:0] req_data = 8'd0;
   logic       rsp_ready = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire [1:0]  rsp_status;
   wire [7:0]  rsp_symbol;
   wire [4:0]  rsp_code_length;
   wire [8:0]  rsp_bytes_read;
   wire        rsp_overfull;

   jpeg_huffman_table_decoder_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_table_start(req_table_start),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_symbol(rsp_symbol),
      .rsp_code_length(rsp_code_length),
      .rsp_bytes_read(rsp_bytes_read),
      .rsp_overfull(rsp_overfull)
   );

   // Decoder state as the block should hold it.
   logic [7:0]  len_count [MAX_LEN];
   logic [7:0]  sym_mem [STORE_DEPTH];
   int unsigned code_lim [MAX_LEN];
   int unsigned first_idx [MAX_LEN];
   int unsigned load_pos;
   int unsigned accum;
   int unsigned nbits;
   bit          tbl_valid;
   bit          ovf_seen;

   dec_result_type expected_q [$];
   dec_result_type want;
   dec_result_type pred_res;
   bit             pred_got;
   logic           pend_typed = 1'b0;
   dec_result_type pend_res = '0;
   int             errors = 0;
   int             items_sent = 0;
   int             phase = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int unsigned symbols_listed();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < MAX_LEN; i++) sum += len_count[i];
      return sum;
   endfunction

   function automatic int unsigned symbols_kept();
      int unsigned sum;
      sum = symbols_listed();
      return (sum > STORE_DEPTH) ? STORE_DEPTH : sum;
   endfunction

   function automatic int unsigned first_code(input int unsigned len);
      return (len <= 1) ? 0 : 2 * code_lim[len - 2];
   endfunction

   function automatic int unsigned longest_len();
      int unsigned best;
      best = 1;
      for (int unsigned l = 1; l <= MAX_LEN; l++)
         if (code_lim[l - 1] > first_code(l)) best = l;
      return best;
   endfunction

   // Canonical code assignment: each length continues from the doubled end of
   // the previous one. Symbols past the free space keep their slot but no code.
   task automatic build_codes();
      int unsigned left, idx, nxt, n, space, placed;
      left = symbols_kept();
      idx = 0;
      nxt = 0;
      if (symbols_listed() > STORE_DEPTH) ovf_seen = 1'b1;
      for (int i = 0; i < MAX_LEN; i++) begin
         n = len_count[i];
         if (n > left) n = left;
         left -= n;
         first_idx[i] = idx;
         space = (32'd1 << (i + 1)) - nxt;
         placed = (n < space) ? n : space;
         if (n > space) ovf_seen = 1'b1;
         nxt += placed;
         code_lim[i] = nxt;
         if (i + 1 < MAX_LEN) nxt <<= 1;
         idx += n;
      end
   endtask

   task automatic decode_step(input logic k, input logic st, input logic [7:0] d,
                              output bit got, output dec_result_type r);
      int unsigned len, fc, idx;
      got = 1'b0;
      r = NO_RES;
      if (k == KIND_BYTE) begin
         if (st) begin
            for (int i = 0; i < MAX_LEN; i++) len_count[i] = 8'd0;
            load_pos = 0;
            tbl_valid = 1'b0;
            ovf_seen = 1'b0;
            accum = 0;
            nbits = 0;
         end
         if (tbl_valid) return;
         if (load_pos < MAX_LEN) begin
            len_count[load_pos] = d;
            load_pos++;
            if (load_pos < MAX_LEN || symbols_kept() != 0) return;
         end else begin
            if (load_pos - MAX_LEN < STORE_DEPTH) sym_mem[load_pos - MAX_LEN] = d;
            load_pos = (load_pos + 1) & 32'h1FF;
            if (load_pos - MAX_LEN < symbols_kept()) return;
         end
         build_codes();
         tbl_valid = 1'b1;
         got = 1'b1;
         r = '{ST_LOADED, 8'd0, 5'd0, load_pos[8:0], ovf_seen};
         return;
      end
      got = 1'b1;
      if (!tbl_valid) begin
         accum = 0;
         nbits = 0;
         r = '{ST_INVALID, 8'd0, 5'd1, 9'd0, ovf_seen};
         return;
      end
      accum = ((accum << 1) | d[0]) & 32'hFFFF;
      nbits++;
      len = nbits;
      fc = first_code(len);
      if (accum < code_lim[len - 1] && accum >= fc) begin
         idx = first_idx[len - 1] + accum - fc;
         r = '{ST_SYMBOL, (idx < STORE_DEPTH) ? sym_mem[idx] : 8'd0, len[4:0], 9'd0,
               ovf_seen};
         accum = 0;
         nbits = 0;
      end else if (len >= longest_len()) begin
         r = '{ST_INVALID, 8'd0, len[4:0], 9'd0, ovf_seen};
         accum = 0;
         nbits = 0;
      end else begin
         got = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_status, " symbol %0d length %0d bytes %0d overfull %0d",
                        rsp_symbol, rsp_code_length, rsp_bytes_read, rsp_overfull);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("symbol", want.symbol, rsp_symbol);
               check_field("code_length", want.code_length, rsp_code_length);
               check_field("bytes_read", want.bytes_read, rsp_bytes_read);
               check_field("overfull", want.overfull, rsp_overfull);
            end
         end
         if (req_valid && req_ready) begin
            decode_step(req_kind, req_table_start, req_data, pred_got, pred_res);
            if (pend_typed) expected_q.push_back(pend_res);
            else if (pred_got) expected_q.push_back(pred_res);
         end
      end
   end

   always @(negedge clock) begin
      if (phase == 2) rsp_ready <= ($urandom_range(0, 99) >= 63);
      else if (phase == 3) rsp_ready <= ($urandom_range(0, 99) >= 13);
      else rsp_ready <= 1'b1;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic k, input logic st, input logic [7:0] d,
                            input logic typed = 1'b0, input dec_result_type tr = '0);
      int  idle_pct;
      bit  ignored;
      idle_pct = (phase == 1) ? 63 : (phase == 3) ? 13 : 0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      ignored = (k == KIND_BYTE) && !st && tbl_valid;
      req_valid <= 1'b1;
      req_kind <= k;
      req_table_start <= st;
      req_data <= d;
      pend_typed <= typed;
      pend_res <= tr;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!ignored) items_sent++;
      phase = (items_sent / 60) % 4;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0);
   endtask

   // Sends one code that the loaded table holds, most significant bit first.
   task automatic send_code();
      int unsigned lens [$];
      int unsigned len, fc, code;
      for (int unsigned l = 1; l <= MAX_LEN; l++)
         if (tbl_valid && code_lim[l - 1] > first_code(l)) lens.push_back(l);
      if (lens.size() == 0) begin
         send_item(KIND_BIT, 1'($urandom), 8'($urandom));
         return;
      end
      len = lens[$urandom_range(0, lens.size() - 1)];
      fc = first_code(len);
      code = $urandom_range(fc, code_lim[len - 1] - 1);
      for (int b = len - 1; b >= 0; b--)
         send_item(KIND_BIT, 1'($urandom), {7'($urandom), code[b]});
   endtask

   task automatic load_table(input int profile, input bit with_start);
      logic [7:0]  cnt [MAX_LEN];
      int unsigned total, nxt, avail, top, n;
      nxt = 0;
      total = 0;
      if (profile == PROF_OVER) top = $urandom_range(1, 7);
      else if ($urandom_range(0, 3) == 0) top = $urandom_range(9, MAX_LEN);
      else top = $urandom_range(1, 8);
      for (int i = 0; i < MAX_LEN; i++) begin
         n = 0;
         if (profile == PROF_HUGE) begin
            n = $urandom_range(0, 255);
         end else if (profile != PROF_EMPTY && i < top) begin
            avail = (32'd1 << (i + 1)) - nxt;
            n = $urandom_range(0, (avail < 4) ? avail : 4);
            if (i == top - 1) begin
               if (profile == PROF_OVER) n = avail + $urandom_range(1, 3);
               else if ($urandom_range(0, 1) == 1) n = (avail < 8) ? avail : 8;
            end
            nxt = (nxt + n) << 1;
         end
         cnt[i] = n[7:0];
      end
      if (profile == PROF_HUGE) begin
         cnt[7] = 8'd200;
         cnt[15] = 8'd255;
      end
      for (int i = 0; i < MAX_LEN; i++) begin
         total += cnt[i];
         send_item(KIND_BYTE, with_start && (i == 0), cnt[i]);
      end
      if (total > STORE_DEPTH) total = STORE_DEPTH;
      for (int unsigned i = 0; i < total; i++) send_item(KIND_BYTE, 1'b0, 8'($urandom));
   endtask

   initial begin
      int  sel, prof;
      bit  huge_done;
      huge_done = 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
         len_count[i] = 8'd0;
         code_lim[i] = 0;
         first_idx[i] = 0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) sym_mem[i] = 8'd0;
      load_pos = 0;
      accum = 0;
      nbits = 0;
      tbl_valid = 1'b0;
      ovf_seen = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++)
         send_item(SCRIPT[i].kind, SCRIPT[i].start, SCRIPT[i].data, SCRIPT[i].typed,
                   SCRIPT[i].res);
      drain_all();

      while (items_sent < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (!huge_done && items_sent > 300) begin
            load_table(PROF_HUGE, 1'b1);
            huge_done = 1'b1;
         end else if (sel < 20) begin
            prof = $urandom_range(0, 9);
            load_table((prof == 0) ? PROF_EMPTY : (prof < 3) ? PROF_OVER : PROF_CANON,
                       $urandom_range(0, 9) != 0);
         end else if (sel < 70) begin
            repeat ($urandom_range(1, 6)) send_code();
         end else if (sel < 82) begin
            repeat ($urandom_range(1, 12)) send_item(KIND_BIT, 1'($urandom), 8'($urandom));
         end else if (sel < 88) begin
            send_item(KIND_BYTE, 1'b0, 8'($urandom));
         end else if (sel < 94) begin
            // Aborted load: a few count bytes, then whatever comes next.
            send_item(KIND_BYTE, 1'b1, 8'($urandom));
            repeat ($urandom_range(0, 18)) send_item(KIND_BYTE, 1'b0, 8'($urandom));
         end else begin
            drain_all();
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (expected_q.size() != 0);
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
sv/hjd_pkg.sv
sv/hjd_ram.sv
sv/hjd_front.sv
sv/hjd_queue.sv
sv/hjd_back.sv
sv/jpeg_huffman_table_decoder_top.sv
bench/tb_jpeg_huffman_table_decoder_top.sv
